FILE: hdl/rvg_pkg.sv
// Shared constants and types for the vertical gridline ray walker.
// No dependencies; the other files, rvg_ram apart, refer to it by scoped names.
`default_nettype none

package rvg_pkg;

  // Tile edge in pixels; must be a power of two (2 to 256).
  localparam int TilePixels = 64;
  // Tile edge in Q8 pixels is 2**TileShift.
  localparam int TileShift  = $clog2(TilePixels) + 8;
  localparam int MaxRowsDef = 64;
  localparam int MaxColsDef = 64;

  localparam int PosW  = 24;               // Q15.8 positions
  localparam int TanW  = 32;               // Q15.16 tangent
  localparam int RowW  = 34;               // walking row position, signed
  localparam int ColW  = 26;               // walking column position, signed
  localparam int AdjW  = TileShift + 1;    // distance to first gridline
  localparam int ProdW = TanW + AdjW;
  localparam int SqW   = 2 * PosW;
  localparam int RadW  = 50;               // radicand of the distance root
  localparam int RootW = RadW / 2;
  localparam int LenW  = 7;                // row length and map_rows width

  typedef logic [1:0] action_t;
  localparam action_t ActCell   = 2'd0;
  localparam action_t ActRowLen = 2'd1;
  localparam action_t ActCast   = 2'd2;

endpackage

`default_nettype wire

FILE: hdl/rvg_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module rvg_ram #(
  parameter int Width = 1,
  parameter int Depth = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hdl/rvg_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on rvg_pkg for the radicand and root widths.
`default_nettype none

module rvg_sqrt (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [rvg_pkg::RadW-1:0]   rad_i,
  output logic                            done_o,
  output logic      [rvg_pkg::RootW-1:0]  root_o
);

  localparam int RootW = rvg_pkg::RootW;
  localparam int RadW  = rvg_pkg::RadW;
  localparam int RemW  = RootW + 2;
  localparam int CntW  = $clog2(RootW);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [RadW-1:0]   rad_q, rad_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [RootW-1:0]  root_q, root_d;
  logic [RemW-1:0]   rem_sh;
  logic [RemW-1:0]   trial;

  always_comb begin
    rem_sh = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
    trial  = {root_q, 2'b01};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d = rad_q << 2;
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(RootW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

FILE: hdl/ray_vertical_grid_hit.sv
// Vertical gridline ray walker: tile map in two RAMs, walk sequencer, distance root.
// Depends on rvg_pkg, rvg_ram and rvg_sqrt.
//
// Usage: one input channel (valid/ready) carries map writes and cast items; one
// output channel (valid/ready) carries one hit point and distance per cast.
// A config channel (cfg_valid_i/cfg_ready_o, always ready) sets map_rows; write
// it only while no cast is in flight.
// Cell and row length writes give no result.
// A cast runs setup (S_MUL, S_ROW), then for each gridline tested one RAM read of
// wall bit and row length (S_READ) and an evaluation (S_EVAL), then squaring
// (S_SQR1, S_SQR2), the root (S_ROOT) and the load of the result (S_OUT).
// After reset the block sweeps both RAMs to zero, one entry a cycle, with input ready low.
// The result sits in an output register; a new item is accepted while it waits.
// When the receiver stalls with a result still held, the next cast finishes and
// then holds until the register frees.
`default_nettype none

module ray_vertical_grid_hit #(
  parameter int MaxRows = rvg_pkg::MaxRowsDef,
  parameter int MaxCols = rvg_pkg::MaxColsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [rvg_pkg::LenW-1:0]       cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [1:0]                     action_i,
  input  wire logic [5:0]                     cell_row_i,
  input  wire logic [5:0]                     cell_col_i,
  input  wire logic                           is_wall_i,
  input  wire logic [6:0]                     row_length_i,
  input  wire logic signed [23:0]             player_row_i,
  input  wire logic signed [23:0]             player_col_i,
  input  wire logic signed [31:0]             tan_angle_i,
  input  wire logic                           faces_right_i,
  input  wire logic                           faces_up_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic signed [23:0]                  hit_row_o,
  output logic signed [23:0]                  hit_col_o,
  output logic [23:0]                         distance_o
);

  localparam int TS    = rvg_pkg::TileShift;
  localparam int RowW  = rvg_pkg::RowW;
  localparam int ColW  = rvg_pkg::ColW;
  localparam int AdjW  = rvg_pkg::AdjW;
  localparam int ProdW = rvg_pkg::ProdW;
  localparam int TanW  = rvg_pkg::TanW;
  localparam int PosW  = rvg_pkg::PosW;
  localparam int SqW   = rvg_pkg::SqW;
  localparam int RadW  = rvg_pkg::RadW;
  localparam int RootW = rvg_pkg::RootW;
  localparam int LenW  = rvg_pkg::LenW;
  localparam int RW    = $clog2(MaxRows);
  localparam int CW    = $clog2(MaxCols);
  localparam int AW    = RW + CW;
  localparam int WallD = MaxRows * (2 ** CW);
  localparam int RmagW = TanW + TS - 16;

  localparam logic signed [ColW-1:0] Tile      = ColW'(1) <<< TS;
  localparam logic signed [RowW-1:0] MaxRowLim = RowW'(MaxRows) <<< TS;
  localparam logic signed [ColW-1:0] MaxColLim = ColW'(MaxCols) <<< TS;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_MUL   = 10'b0000000100,
    S_ROW   = 10'b0000001000,
    S_READ  = 10'b0000010000,
    S_EVAL  = 10'b0000100000,
    S_SQR1  = 10'b0001000000,
    S_SQR2  = 10'b0010000000,
    S_ROOT  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  function automatic logic [PosW-1:0] sat24(input logic signed [RowW-1:0] v);
    logic [PosW-1:0] r;
    if ((&v[RowW-1:PosW-1]) || !(|v[RowW-1:PosW-1])) begin
      r = v[PosW-1:0];
    end else begin
      r = v[RowW-1] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
    end
    return r;
  endfunction

  state_e                  state_q, state_d;
  logic [AW-1:0]           clr_q, clr_d;
  logic [LenW-1:0]         map_rows_q;
  logic signed [PosW-1:0]  pr_q, pc_q;
  logic [TanW-1:0]         tmag_q;
  logic                    right_q, up_q, first_q, big_q;
  logic [ProdW-1:0]        prod_q;
  logic signed [RowW-1:0]  row_q, row_d;
  logic signed [ColW-1:0]  col_q, col_d;
  logic [SqW-1:0]          acc_q;
  logic                    out_valid_q;
  logic [PosW-1:0]         hit_row_q, hit_col_q, dist_q;

  logic                    in_fire, clearing;
  logic [RW-1:0]           wr_row;
  logic [CW-1:0]           wr_col;
  logic                    row_ok, col_ok;
  logic                    wall_we, rl_we;
  logic [AW-1:0]           wall_waddr, wall_raddr;
  logic [RW-1:0]           rl_waddr;
  logic                    wall_wdata, wall_rdata;
  logic [LenW-1:0]         rl_wdata, rl_rdata;

  logic signed [ColW-1:0]  pc_ext, col_fl, col0, adj_full, probe, col_lim;
  logic signed [RowW-1:0]  opp, rstep, row_lim;
  logic [TanW+TS-1:0]      tsh;
  logic [RmagW-1:0]        rmag;
  logic signed [8:0]       rows_m1, len_m1;
  logic                    row_out, brk, blk, stop;
  logic signed [RowW-1:0]  dr_s;
  logic signed [ColW-1:0]  dc_s;
  logic [RowW-1:0]         dr_abs;
  logic [ColW-1:0]         dc_abs;
  logic                    big;
  logic [PosW-1:0]         sq_in;
  logic [SqW-1:0]          sq;
  logic                    sq_start, sq_done;
  logic [RadW-1:0]         radicand;
  logic [RootW-1:0]        root;
  logic                    out_free;

  assign clearing    = (state_q == S_CLEAR);
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Map write decode
  assign wr_row = RW'(cell_row_i);
  assign wr_col = CW'(cell_col_i);
  assign row_ok = int'(cell_row_i) < MaxRows;
  assign col_ok = int'(cell_col_i) < MaxCols;

  assign wall_we    = clearing ||
                      (in_fire && action_i == rvg_pkg::ActCell && row_ok && col_ok);
  assign wall_waddr = clearing ? clr_q : {wr_row, wr_col};
  assign wall_wdata = clearing ? 1'b0 : is_wall_i;
  assign rl_we      = clearing || (in_fire && action_i == rvg_pkg::ActRowLen && row_ok);
  assign rl_waddr   = clearing ? clr_q[CW +: RW] : wr_row;
  assign rl_wdata   = clearing ? '0 : row_length_i;

  // Setup arithmetic
  assign pc_ext   = ColW'(pc_q);
  assign col_fl   = (pc_ext >>> TS) <<< TS;
  assign col0     = right_q ? col_fl + Tile : col_fl;
  assign adj_full = right_q ? col0 - pc_ext : pc_ext - col0;
  assign opp      = $signed(RowW'(prod_q[ProdW-1:16]));
  assign tsh      = {tmag_q, TS'(0)};
  assign rmag     = tsh[TanW+TS-1:16];
  assign rstep    = up_q ? -$signed(RowW'(rmag)) : $signed(RowW'(rmag));

  // Probe column sits just left of the gridline when facing left
  assign probe      = right_q ? col_q : col_q - ColW'(256);
  assign wall_raddr = {row_q[TS +: RW], probe[TS +: CW]};

  assign rows_m1 = $signed({2'b00, map_rows_q}) - 9'sd1;
  assign len_m1  = $signed({2'b00, rl_rdata}) - 9'sd1;
  assign row_lim = RowW'(rows_m1) <<< TS;
  assign col_lim = ColW'(len_m1) <<< TS;

  // Range tests are done on positions; row range gates the use of row length
  assign row_out = row_q[RowW-1] || (row_q >= row_lim) || (row_q >= MaxRowLim);
  assign brk     = row_out || col_q[ColW-1] || (col_q >= col_lim);
  assign blk     = row_out || (probe < Tile) || (probe >= col_lim) ||
                   (probe >= MaxColLim) || wall_rdata;
  assign stop    = blk || (!first_q && brk);

  // Distance
  assign dr_s   = row_q - RowW'(pr_q);
  assign dc_s   = col_q - pc_ext;
  assign dr_abs = dr_s[RowW-1] ? RowW'(-dr_s) : RowW'(dr_s);
  assign dc_abs = dc_s[ColW-1] ? ColW'(-dc_s) : ColW'(dc_s);
  assign big    = (|dr_abs[RowW-1:PosW]) || (|dc_abs[ColW-1:PosW]);
  assign sq_in  = (state_q == S_SQR1) ? dr_abs[PosW-1:0] : dc_abs[PosW-1:0];
  assign sq     = SqW'(sq_in) * SqW'(sq_in);
  assign sq_start = (state_q == S_SQR2);
  assign radicand = RadW'(acc_q) + RadW'(sq);

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    row_d   = row_q;
    col_d   = col_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(WallD - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire && action_i == rvg_pkg::ActCast) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        col_d   = col0;
        state_d = S_ROW;
      end
      S_ROW: begin
        row_d   = up_q ? RowW'(pr_q) - opp : RowW'(pr_q) + opp;
        state_d = S_READ;
      end
      S_READ: state_d = S_EVAL;
      S_EVAL: begin
        if (stop) begin
          state_d = S_SQR1;
        end else begin
          // advance to the next gridline
          row_d   = row_q + rstep;
          col_d   = right_q ? col_q + Tile : col_q - Tile;
          state_d = S_READ;
        end
      end
      S_SQR1: state_d = S_SQR2;
      S_SQR2: state_d = S_ROOT;
      S_ROOT: begin
        if (sq_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      map_rows_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (cfg_valid_i) begin
        map_rows_q <= cfg_data_i;
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    col_q <= col_d;
    if (in_fire) begin
      pr_q    <= player_row_i;
      pc_q    <= player_col_i;
      tmag_q  <= tan_angle_i[TanW-1] ? ~tan_angle_i + TanW'(1) : tan_angle_i;
      right_q <= faces_right_i;
      up_q    <= faces_up_i;
    end
    if (state_q == S_MUL) begin
      prod_q <= ProdW'(tmag_q) * ProdW'(adj_full[AdjW-1:0]);
    end
    if (state_q == S_ROW) begin
      first_q <= 1'b1;
    end else if (state_q == S_EVAL) begin
      first_q <= 1'b0;
    end
    if (state_q == S_SQR1) begin
      acc_q <= sq;
      big_q <= big;
    end
    if (state_q == S_OUT && out_free) begin
      hit_row_q <= sat24(row_q);
      hit_col_q <= sat24(RowW'(col_q));
      dist_q    <= (big_q || root[RootW-1]) ? '1 : root[PosW-1:0];
    end
  end

  rvg_ram #(.Width(1), .Depth(WallD)) u_wall_ram (
    .clk_i   (clk_i),
    .we_i    (wall_we),
    .waddr_i (wall_waddr),
    .wdata_i (wall_wdata),
    .raddr_i (wall_raddr),
    .rdata_o (wall_rdata)
  );

  rvg_ram #(.Width(LenW), .Depth(MaxRows)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (rl_we),
    .waddr_i (rl_waddr),
    .wdata_i (rl_wdata),
    .raddr_i (row_q[TS +: RW]),
    .rdata_o (rl_rdata)
  );

  rvg_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (radicand),
    .done_o  (sq_done),
    .root_o  (root)
  );

  assign out_valid_o = out_valid_q;
  assign hit_row_o   = hit_row_q;
  assign hit_col_o   = hit_col_q;
  assign distance_o  = dist_q;

endmodule

`default_nettype wire

FILE: hdl/rvg_checker.sv
// Port-level checks for ray_vertical_grid_hit, attached by bind.
// Depends on rvg_pkg for the action codes.
`default_nettype none

module rvg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [1:0]  action_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [23:0] hit_row_o,
  input wire logic [23:0] distance_o
);

  logic cast_fire, write_fire;

  assign cast_fire  = in_valid_i && in_ready_o && action_i == rvg_pkg::ActCast;
  assign write_fire = in_valid_i && in_ready_o && action_i != rvg_pkg::ActCast;

  // a cast occupies the walker: no new transfer in the next cycle
  a_cast_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cast_fire |=> !in_ready_o)
    else $error("input ready right after a cast transfer");

  // a cast cannot produce its result in the next cycle
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cast_fire |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after a cast");

  // map writes never create a result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_fire && !out_valid_o |=> !out_valid_o)
    else $error("result after a map write");

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(hit_row_o) && $stable(distance_o))
    else $error("stalled result changed");

endmodule

bind ray_vertical_grid_hit rvg_checker u_rvg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .action_i    (action_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .hit_row_o   (hit_row_o),
  .distance_o  (distance_o)
);

`default_nettype wire

FILE: tb/tb.sv
// Self-checking bench for ray_vertical_grid_hit: map writes, casts, map_rows settings.
// Depends on rvg_pkg and the block; carries its own model of the gridline walk.
`timescale 1ns / 1ps

module tb;

  localparam longint          Tile     = longint'(rvg_pkg::TilePixels) * 256;
  localparam int              LenW     = rvg_pkg::LenW;
  localparam rvg_pkg::action_t ActNone = 2'd3;
  localparam int              StallCap = 20000;

  typedef struct {
    rvg_pkg::action_t act;
    logic [5:0]       row;
    logic [5:0]       col;
    logic             wall;
    logic [6:0]       len;
    logic signed [23:0] pr;
    logic signed [23:0] pc;
    logic signed [31:0] tan;
    logic             right;
    logic             up;
  } item_t;

  typedef struct {
    logic signed [23:0] hit_row;
    logic signed [23:0] hit_col;
    logic [23:0]        hit_dist;
  } hit_t;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [LenW-1:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic [1:0] action_i;
  logic [5:0] cell_row_i, cell_col_i;
  logic is_wall_i;
  logic [6:0] row_length_i;
  logic signed [23:0] player_row_i, player_col_i;
  logic signed [31:0] tan_angle_i;
  logic faces_right_i, faces_up_i;
  logic out_valid_o, out_ready_i;
  logic signed [23:0] hit_row_o, hit_col_o;
  logic [23:0] distance_o;

  // model state
  bit   wall_bits [64][64];
  int   lens [64];
  int   rows_in_use;
  hit_t pending_hits [$];

  int   errors;
  int   idle_cycles;
  bit   quiet;
  int   out_hold;

  ray_vertical_grid_hit u_top (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_ready_o, .action_i, .cell_row_i, .cell_col_i, .is_wall_i,
    .row_length_i, .player_row_i, .player_col_i, .tan_angle_i, .faces_right_i,
    .faces_up_i, .out_valid_o, .out_ready_i, .hit_row_o, .hit_col_o, .distance_o
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic bit wall_at(longint r, longint c);
    longint ri, ci;
    ri = floor_div(r, Tile);
    ci = floor_div(c, Tile);
    if (ri < 0 || ri >= rows_in_use - 1 || ri >= 64) return 1'b1;
    if (ci <= 0 || ci >= lens[ri] - 1 || ci >= 64) return 1'b1;
    return wall_bits[ri][ci];
  endfunction

  function automatic logic signed [23:0] clamp24(longint v);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    for (int i = 0; i < 32; i++) begin
      b = 64'd1 << (62 - 2 * i);
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic hit_t trace_ray(item_t it);
    longint pr, pc, tm, col, adj, opp, row, rstep, cstep, dr, dc, ri;
    longint unsigned q;
    hit_t h;
    pr = it.pr;
    pc = it.pc;
    tm = it.tan;
    if (tm < 0) tm = -tm;
    col = floor_div(pc, Tile) * Tile;
    if (it.right) col += Tile;
    adj = it.right ? col - pc : pc - col;
    opp = (tm * adj) >>> 16;
    row = it.up ? pr - opp : pr + opp;
    rstep = (tm * Tile) >>> 16;
    if (it.up) rstep = -rstep;
    cstep = it.right ? Tile : -Tile;
    while (!wall_at(row, col - (it.right ? 0 : 256))) begin
      row += rstep;
      col += cstep;
      if (row < 0 || row >= (longint'(rows_in_use) - 1) * Tile) break;
      ri = floor_div(row, Tile);
      if (ri >= 64) break;
      if (col < 0 || col >= (longint'(lens[ri]) - 1) * Tile) break;
    end
    dr = row - pr;
    dc = col - pc;
    if (dr < 0) dr = -dr;
    if (dc < 0) dc = -dc;
    if (dr >= 16777216 || dc >= 16777216) begin
      q = 16777215;
    end else begin
      q = int_sqrt(dr * dr + dc * dc);
      if (q > 16777215) q = 16777215;
    end
    h.hit_row  = clamp24(row);
    h.hit_col  = clamp24(col);
    h.hit_dist = q[23:0];
    return h;
  endfunction

  // apply one accepted item to the model
  function automatic void absorb_item(item_t it);
    unique case (it.act)
      rvg_pkg::ActCell:   wall_bits[it.row][it.col] = it.wall;
      rvg_pkg::ActRowLen: lens[it.row] = it.len;
      rvg_pkg::ActCast:   pending_hits.push_back(trace_ray(it));
      default: ;
    endcase
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result side: random hold per transfer, compare in order
  always @(posedge clk_i or negedge rst_ni) begin
    hit_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_hits.size() == 0) begin
          report("unexpected result", hit_row_o, 0);
        end else begin
          e = pending_hits.pop_front();
          if (hit_row_o !== e.hit_row) report("hit_row", hit_row_o, e.hit_row);
          if (hit_col_o !== e.hit_col) report("hit_col", hit_col_o, e.hit_col);
          if (distance_o !== e.hit_dist) report("distance", distance_o, e.hit_dist);
        end
        out_hold = quiet ? 0 : $urandom_range(0, 8);
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_ready_i <= (out_hold == 0);
    end
  end

  // stop when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= StallCap) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    action_i      <= it.act;
    cell_row_i    <= it.row;
    cell_col_i    <= it.col;
    is_wall_i     <= it.wall;
    row_length_i  <= it.len;
    player_row_i  <= it.pr;
    player_col_i  <= it.pc;
    tan_angle_i   <= it.tan;
    faces_right_i <= it.right;
    faces_up_i    <= it.up;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    absorb_item(it);
  endtask

  function automatic item_t junk_item(rvg_pkg::action_t a);
    item_t it;
    it.act   = a;
    it.row   = 6'($urandom);
    it.col   = 6'($urandom);
    it.wall  = 1'($urandom);
    it.len   = 7'($urandom_range(0, 64));
    it.pr    = 24'($urandom);
    it.pc    = 24'($urandom);
    it.tan   = $urandom;
    it.right = 1'($urandom);
    it.up    = 1'($urandom);
    return it;
  endfunction

  task automatic write_cell(int r, int c, bit w);
    item_t it;
    it = junk_item(rvg_pkg::ActCell);
    it.row = 6'(r); it.col = 6'(c); it.wall = w;
    send_item(it);
  endtask

  task automatic write_len(int r, int n);
    item_t it;
    it = junk_item(rvg_pkg::ActRowLen);
    it.row = 6'(r); it.len = 7'(n);
    send_item(it);
  endtask

  task automatic cast(longint pr, longint pc, longint tn, bit right, bit up);
    item_t it;
    it = junk_item(rvg_pkg::ActCast);
    it.pr = 24'(pr); it.pc = 24'(pc); it.tan = 32'(tn); it.right = right; it.up = up;
    send_item(it);
  endtask

  // drain results, let trailing writes settle, then set map_rows
  task automatic set_rows(int n);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_data_i  <= LenW'(n);
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    rows_in_use = n;
  endtask

  task automatic random_cast();
    longint pr, pc, tn;
    if ($urandom_range(0, 7) == 0) begin
      pr = $signed(24'($urandom));
      pc = $signed(24'($urandom));
    end else begin
      pr = $urandom_range(0, (rows_in_use + 1) * 16384);
      pc = $urandom_range(0, 65 * 16384);
    end
    case ($urandom_range(0, 5))
      0:       tn = $signed(32'($urandom));
      1:       tn = $urandom_range(0, 32'h0010_0000);
      default: tn = $urandom_range(0, 32'h0003_0000);
    endcase
    if ($urandom_range(0, 1)) tn = -tn;
    cast(pr, pc, tn, 1'($urandom), 1'($urandom));
  endtask

  task automatic test_empty_map();
    set_rows(0);
    cast(0, 0, 0, 1, 1);
    cast(100000, 200000, 32'h0001_0000, 0, 0);
    cast(-8388608, -8388608, -32'sd2147483648, 1, 0);
    cast(8388607, 8388607, 32'sh7fff_ffff, 0, 1);
    cast(8388607, -8388608, -32'sd2147483648, 0, 0);
    set_rows(1);
    cast(5000, 70000, 32'h0000_8000, 1, 1);
    cast(-5000, -70000, 32'hffff_8000, 0, 0);
  endtask

  task automatic test_directed_map();
    item_t it;
    set_rows(64);
    for (int r = 0; r < 8; r++) write_len(r, 64);
    write_len(63, 0);
    write_cell(0, 0, 1);
    write_cell(63, 63, 1);
    write_cell(3, 10, 1);
    write_cell(3, 10, 0);
    write_cell(2, 5, 1);
    it = junk_item(ActNone);
    send_item(it);
    // straight horizontal rays (zero tangent) run to the row end or a wall; slanted rays follow
    cast(2 * 16384 + 8000, 3 * 16384 + 100, 0, 1, 1);
    cast(2 * 16384 + 8000, 40 * 16384 + 100, 0, 0, 1);
    cast(4 * 16384, 20 * 16384, 0, 1, 0);
    cast(3 * 16384 + 1, 20 * 16384, 32'h0000_4000, 1, 0);
    cast(6 * 16384, 30 * 16384, 32'h0002_0000, 0, 1);
    cast(1 * 16384, 60 * 16384, 32'h7fff_ffff, 1, 1);
  endtask

  task automatic test_random_maps();
    for (int m = 0; m < 8; m++) begin
      quiet = (m % 3 == 2);
      set_rows(m == 0 ? 64 : m == 1 ? 2 : $urandom_range(2, 64));
      for (int r = 0; r < 64; r++)
        write_len(r, $urandom_range(0, 3) == 0 ? $urandom_range(0, 64) : $urandom_range(40, 64));
      for (int w = 0; w < 40; w++)
        write_cell($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 3) == 0);
      for (int c = 0; c < 70; c++) random_cast();
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0; cfg_data_i = '0;
    in_valid_i = 1'b0; action_i = '0; cell_row_i = '0; cell_col_i = '0;
    is_wall_i = 1'b0; row_length_i = '0; player_row_i = '0; player_col_i = '0;
    tan_angle_i = '0; faces_right_i = 1'b0; faces_up_i = 1'b0;
    errors = 0; idle_cycles = 0; quiet = 1'b0; rows_in_use = 0;
    foreach (lens[i]) lens[i] = 0;
    foreach (wall_bits[i, j]) wall_bits[i][j] = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_map();
    test_directed_map();
    test_random_maps();

    in_valid_i <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
